// ===== sv/sfp_pkg.sv =====
package sfp_pkg;

   localparam int SHELF_COUNT_DEFAULT = 16;
   localparam logic [15:0] SHELF_WIDTH_RESET = 16'd100;
   localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;

   localparam logic [1:0] KIND_PLACE = 2'd0;
   localparam logic [1:0] KIND_REPORT = 2'd1;
   localparam logic [1:0] KIND_TOTAL = 2'd2;

   localparam logic [1:0] STATUS_EXISTING = 2'd0;
   localparam logic [1:0] STATUS_NEW = 2'd1;
   localparam logic [1:0] STATUS_DROPPED = 2'd2;

   typedef struct packed {
      logic [15:0] fill;
      logic [15:0] tallest;
   } shelf_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  place_status;
      logic [3:0]  shelf_index;
      logic [15:0] used_width;
      logic [15:0] shelf_height;
      logic [19:0] total_height;
      logic        last_result;
   } result_type;

endpackage

// ===== sv/sfp_shelf_ram.sv =====
module sfp_shelf_ram #(
   parameter int SHELF_COUNT = sfp_pkg::SHELF_COUNT_DEFAULT,
   localparam int IW = (SHELF_COUNT > 1) ? $clog2(SHELF_COUNT) : 1
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [IW-1:0]       rd_addr,
   output sfp_pkg::shelf_type  rd_data,
   input  logic                wr_en,
   input  logic [IW-1:0]       wr_addr,
   input  sfp_pkg::shelf_type  wr_data
);
   import sfp_pkg::*;

   shelf_type mem [SHELF_COUNT];
   shelf_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sfp_scan_ctrl.sv =====
module sfp_scan_ctrl #(
   parameter int SHELF_COUNT = sfp_pkg::SHELF_COUNT_DEFAULT,
   localparam int IW = (SHELF_COUNT > 1) ? $clog2(SHELF_COUNT) : 1,
   localparam int CW = $clog2(SHELF_COUNT + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [15:0]         item_width,
   input  logic [15:0]         item_height,
   input  logic                last_item,
   input  logic [15:0]         shelf_width,
   input  logic                out_free,
   output logic                idle,
   output logic                emit,
   output sfp_pkg::result_type result,
   output logic                rd_en,
   output logic [IW-1:0]       rd_addr,
   input  sfp_pkg::shelf_type  rd_data,
   output logic                wr_en,
   output logic [IW-1:0]       wr_addr,
   output sfp_pkg::shelf_type  wr_data
);
   import sfp_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_PLACE = 3'd2;
   localparam logic [2:0] ST_REPORT = 3'd3;
   localparam logic [2:0] ST_TOTAL = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [15:0]   item_w_ff, item_w_in;
   logic [15:0]   item_h_ff, item_h_in;
   logic          item_last_ff, item_last_in;
   logic [CW-1:0] open_ff, open_in;
   logic [CW-1:0] rd_addr_ff, rd_addr_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] cmp_addr_ff, cmp_addr_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [IW-1:0] res_idx_ff, res_idx_in;
   logic [15:0]   res_used_ff, res_used_in;
   logic [15:0]   res_height_ff, res_height_in;
   logic [19:0]   total_ff, total_in;

   logic [16:0]   fit_sum;
   logic          fits;
   logic          can_read;
   logic [20:0]   total_sum;

   function automatic logic [3:0] low_index(input logic [IW-1:0] idx);
      logic [IW+3:0] ext;
      ext = {4'b0000, idx};
      return ext[3:0];
   endfunction

   assign fit_sum = {1'b0, rd_data.fill} + {1'b0, item_w_ff};
   assign fits = fit_sum <= {1'b0, shelf_width};
   assign can_read = rd_addr_ff < open_ff;
   assign total_sum = {1'b0, total_ff} + {5'b00000, rd_data.tallest};
   assign idle = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      item_w_in = item_w_ff;
      item_h_in = item_h_ff;
      item_last_in = item_last_ff;
      open_in = open_ff;
      rd_addr_in = rd_addr_ff;
      pend_in = pend_ff;
      cmp_addr_in = cmp_addr_ff;
      res_status_in = res_status_ff;
      res_idx_in = res_idx_ff;
      res_used_in = res_used_ff;
      res_height_in = res_height_ff;
      total_in = total_ff;
      rd_en = 1'b0;
      rd_addr = rd_addr_ff[IW-1:0];
      wr_en = 1'b0;
      wr_addr = res_idx_ff;
      wr_data = '{fill: res_used_ff, tallest: res_height_ff};
      emit = 1'b0;
      result = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_w_in = item_width;
               item_h_in = item_height;
               item_last_in = last_item;
               rd_addr_in = '0;
               pend_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pend_in = can_read;
            if (can_read) begin
               rd_en = 1'b1;
               rd_addr_in = rd_addr_ff + CW'(1);
               cmp_addr_in = rd_addr_ff[IW-1:0];
            end
            if (pend_ff && fits) begin
               res_status_in = STATUS_EXISTING;
               res_idx_in = cmp_addr_ff;
               res_used_in = fit_sum[15:0];
               res_height_in = (item_h_ff > rd_data.tallest) ? item_h_ff : rd_data.tallest;
               pend_in = 1'b0;
               state_in = ST_PLACE;
            end else if (!pend_ff && !can_read) begin
               if (open_ff < CW'(SHELF_COUNT)) begin
                  res_status_in = STATUS_NEW;
                  res_idx_in = open_ff[IW-1:0];
                  res_used_in = item_w_ff;
                  res_height_in = item_h_ff;
               end else begin
                  res_status_in = STATUS_DROPPED;
                  res_idx_in = '0;
                  res_used_in = '0;
                  res_height_in = '0;
               end
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            result.kind = KIND_PLACE;
            result.place_status = res_status_ff;
            result.shelf_index = low_index(res_idx_ff);
            result.used_width = res_used_ff;
            result.shelf_height = res_height_ff;
            result.last_result = !item_last_ff;
            if (out_free) begin
               emit = 1'b1;
               wr_en = res_status_ff != STATUS_DROPPED;
               if (res_status_ff == STATUS_NEW) begin
                  open_in = open_ff + CW'(1);
               end
               if (item_last_ff) begin
                  rd_addr_in = '0;
                  pend_in = 1'b0;
                  total_in = '0;
                  state_in = ST_REPORT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REPORT: begin
            result.kind = KIND_REPORT;
            result.shelf_index = low_index(cmp_addr_ff);
            result.used_width = rd_data.fill;
            result.shelf_height = rd_data.tallest;
            if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  emit = 1'b1;
                  total_in = total_sum[20] ? TOTAL_MAX : total_sum[19:0];
               end
               pend_in = can_read;
               if (can_read) begin
                  rd_en = 1'b1;
                  rd_addr_in = rd_addr_ff + CW'(1);
                  cmp_addr_in = rd_addr_ff[IW-1:0];
               end else begin
                  state_in = ST_TOTAL;
               end
            end
         end
         ST_TOTAL: begin
            result.kind = KIND_TOTAL;
            result.total_height = total_ff;
            result.last_result = 1'b1;
            if (out_free) begin
               emit = 1'b1;
               open_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         open_ff <= '0;
         pend_ff <= 1'b0;
         rd_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         open_ff <= open_in;
         pend_ff <= pend_in;
         rd_addr_ff <= rd_addr_in;
      end
      item_w_ff <= item_w_in;
      item_h_ff <= item_h_in;
      item_last_ff <= item_last_in;
      cmp_addr_ff <= cmp_addr_in;
      res_status_ff <= res_status_in;
      res_idx_ff <= res_idx_in;
      res_used_ff <= res_used_in;
      res_height_ff <= res_height_in;
      total_ff <= total_in;
   end

endmodule

// ===== sv/shelf_first_fit_packer.sv =====
// Shelf first-fit packer: one placement beat per item, plus shelf reports and a total after a
// last item. The scan reads one shelf entry per cycle from the single-port-read shelf memory,
// then the chosen entry is written back unless the item was dropped. Report beats come out one
// per cycle while the result channel is not stalled.
// Reset is synchronous and active high; it closes all shelves and sets shelf_width to 100.
module shelf_first_fit_packer #(
   parameter int SHELF_COUNT = sfp_pkg::SHELF_COUNT_DEFAULT,
   localparam int IW = (SHELF_COUNT > 1) ? $clog2(SHELF_COUNT) : 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_item_width,
   input  logic [15:0] req_item_height,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_place_status,
   output logic [3:0]  rsp_shelf_index,
   output logic [15:0] rsp_used_width,
   output logic [15:0] rsp_shelf_height,
   output logic [19:0] rsp_total_height,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import sfp_pkg::*;

   logic [15:0] shelf_width_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff;
   logic        idle;
   logic        emit;
   logic        out_free;
   result_type  result;
   logic        rd_en;
   logic [IW-1:0] rd_addr;
   shelf_type   rd_data;
   logic        wr_en;
   logic [IW-1:0] wr_addr;
   shelf_type   wr_data;

   assign csr_ready = 1'b1;
   assign req_stall = !idle;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         shelf_width_ff <= SHELF_WIDTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            shelf_width_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

   sfp_scan_ctrl #(.SHELF_COUNT(SHELF_COUNT)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (req_valid && idle),
      .item_width (req_item_width),
      .item_height(req_item_height),
      .last_item  (req_last_item),
      .shelf_width(shelf_width_ff),
      .out_free   (out_free),
      .idle       (idle),
      .emit       (emit),
      .result     (result),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   sfp_shelf_ram #(.SHELF_COUNT(SHELF_COUNT)) u_ram (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_data_ff.kind;
   assign rsp_place_status = rsp_data_ff.place_status;
   assign rsp_shelf_index = rsp_data_ff.shelf_index;
   assign rsp_used_width = rsp_data_ff.used_width;
   assign rsp_shelf_height = rsp_data_ff.shelf_height;
   assign rsp_total_height = rsp_data_ff.total_height;
   assign rsp_last_result = rsp_data_ff.last_result;

endmodule

// ===== sv/sfp_checker.sv =====
module sfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [1:0]  rsp_place_status,
   input logic [3:0]  rsp_shelf_index,
   input logic [15:0] rsp_used_width,
   input logic [15:0] rsp_shelf_height,
   input logic [19:0] rsp_total_height,
   input logic        rsp_last_result
);
   import sfp_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_used_width)
         && $stable(rsp_total_height) && $stable(rsp_last_result))
      else $error("Stalled result beat changed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind == KIND_PLACE || rsp_kind == KIND_REPORT || rsp_kind == KIND_TOTAL)
      else $error("Result beat carries an unknown kind.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_TOTAL |-> rsp_last_result && rsp_place_status == 2'd0)
      else $error("Total beat is not marked as the final beat.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_REPORT |-> !rsp_last_result && rsp_total_height == 20'd0)
      else $error("Shelf report beat has a bad last flag or total.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PLACE && rsp_place_status == STATUS_DROPPED
         |-> rsp_used_width == 16'd0 && rsp_shelf_height == 16'd0 && rsp_shelf_index == 4'd0)
      else $error("Dropped item reports a shelf.");

endmodule

bind shelf_first_fit_packer sfp_checker u_sfp_checker (.*);

// ===== tb/shelf_first_fit_packer_tb.sv =====
`timescale 1ns / 1ps

module shelf_first_fit_packer_tb;
   import sfp_pkg::*;

   localparam int SHELVES = SHELF_COUNT_DEFAULT;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_item_width = '0;
   logic [15:0] req_item_height = '0;
   logic        req_last_item = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [1:0]  rsp_place_status;
   logic [3:0]  rsp_shelf_index;
   logic [15:0] rsp_used_width;
   logic [15:0] rsp_shelf_height;
   logic [19:0] rsp_total_height;
   logic        rsp_last_result;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   logic [15:0] shelf_width_now;
   logic [15:0] fill_model [SHELVES];
   logic [15:0] tall_model [SHELVES];
   int          open_shelves;
   result_type  pending_results [$];

   int error_count = 0;
   int items_sent = 0;
   int runs_sent = 0;
   int drops_seen = 0;
   int beats_checked = 0;
   int widths_written = 0;
   int hold_off_cycles = 0;
   bit sender_idling = 1'b1;
   bit receiver_idling = 1'b1;

   shelf_first_fit_packer u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item_width(req_item_width),
      .req_item_height(req_item_height),
      .req_last_item(req_last_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_place_status(rsp_place_status),
      .rsp_shelf_index(rsp_shelf_index),
      .rsp_used_width(rsp_used_width),
      .rsp_shelf_height(rsp_shelf_height),
      .rsp_total_height(rsp_total_height),
      .rsp_last_result(rsp_last_result),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic void clear_shelf_model();
      for (int j = 0; j < SHELVES; j++) begin
         fill_model[j] = '0;
         tall_model[j] = '0;
      end
      open_shelves = 0;
   endfunction

   function automatic void place_rectangle(input logic [15:0] w, input logic [15:0] h,
                                           input logic last);
      result_type r;
      int hit;
      int sum;
      hit = -1;
      r = '0;
      r.kind = KIND_PLACE;
      r.place_status = STATUS_DROPPED;
      for (int j = 0; j < open_shelves && hit < 0; j++) begin
         if (int'(fill_model[j]) + int'(w) <= int'(shelf_width_now)) begin
            hit = j;
            fill_model[j] = fill_model[j] + w;
            if (h > tall_model[j]) tall_model[j] = h;
            r.place_status = STATUS_EXISTING;
         end
      end
      if (hit < 0 && open_shelves < SHELVES) begin
         hit = open_shelves;
         fill_model[hit] = w;
         tall_model[hit] = h;
         open_shelves++;
         r.place_status = STATUS_NEW;
      end
      if (hit >= 0) begin
         r.shelf_index = 4'(hit);
         r.used_width = fill_model[hit];
         r.shelf_height = tall_model[hit];
      end else begin
         drops_seen++;
      end
      r.last_result = !last;
      pending_results.push_back(r);
      if (last) begin
         sum = 0;
         for (int j = 0; j < open_shelves; j++) begin
            r = '0;
            r.kind = KIND_REPORT;
            r.shelf_index = 4'(j);
            r.used_width = fill_model[j];
            r.shelf_height = tall_model[j];
            pending_results.push_back(r);
            sum += int'(tall_model[j]);
            if (sum > int'(TOTAL_MAX)) sum = int'(TOTAL_MAX);
         end
         r = '0;
         r.kind = KIND_TOTAL;
         r.total_height = 20'(sum);
         r.last_result = 1'b1;
         pending_results.push_back(r);
         clear_shelf_model();
      end
   endfunction

   function automatic void check_field(input string name, input logic [19:0] want,
                                       input logic [19:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual kind %0d",
                     $time, rsp_kind);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("place_status", want.place_status, rsp_place_status);
            check_field("shelf_index", want.shelf_index, rsp_shelf_index);
            check_field("used_width", want.used_width, rsp_used_width);
            check_field("shelf_height", want.shelf_height, rsp_shelf_height);
            check_field("total_height", want.total_height, rsp_total_height);
            check_field("last_result", want.last_result, rsp_last_result);
         end
      end
   end

   initial begin
      int burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (receiver_idling && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            burst = $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_item(input logic [15:0] w, input logic [15:0] h, input logic last);
      int gap;
      if (sender_idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_item_width <= w;
      req_item_height <= h;
      req_last_item <= last;
      do @(posedge clock); while (req_stall);
      place_rectangle(w, h, last);
      items_sent++;
      if (last) runs_sent++;
   endtask

   task automatic release_input();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      release_input();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_shelf_width(input logic [15:0] value);
      wait_drained();
      repeat (SHELVES + 8) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      shelf_width_now = value;
      widths_written++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_run(input int len, input bit close_run);
      int h;
      logic [15:0] w;
      logic [15:0] item_h;
      bit noisy;
      noisy = ($urandom_range(0, 5) == 0);
      h = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(1, 65535);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0: w = 16'($urandom);
            1: w = shelf_width_now;
            2: w = 16'd0;
            default: w = 16'($urandom_range(0, (int'(shelf_width_now) + 2) / 3));
         endcase
         item_h = noisy ? 16'($urandom) : 16'(h);
         h = h - $urandom_range(0, h / 3);
         send_item(w, item_h, close_run && (i == len - 1));
      end
   endtask

   task automatic test_directed_default_width();
      send_item(16'd100, 16'd50, 1'b0);
      send_item(16'd1, 16'd40, 1'b0);
      send_item(16'd99, 16'd30, 1'b0);
      send_item(16'd0, 16'd20, 1'b0);
      send_item(16'hFFFF, 16'hFFFF, 1'b0);
      send_item(16'd5, 16'd10, 1'b1);
   endtask

   task automatic test_zero_width_and_drop();
      write_shelf_width(16'd0);
      send_item(16'd0, 16'd500, 1'b0);
      send_item(16'd0, 16'd700, 1'b0);
      for (int i = 1; i < SHELVES; i++) send_item(16'hFFFF, 16'(65535 - i), 1'b0);
      send_item(16'd7, 16'd9, 1'b0);
      send_item(16'd0, 16'hFFFF, 1'b1);
   endtask

   task automatic test_random_widths();
      logic [15:0] settings [5];
      int sent;
      int len;
      settings[0] = 16'd1;
      settings[1] = 16'hFFFF;
      settings[2] = 16'd100;
      settings[3] = 16'($urandom_range(2, 64));
      settings[4] = 16'($urandom_range(1, 65535));
      foreach (settings[k]) begin
         write_shelf_width(settings[k]);
         sender_idling = 1'($urandom_range(0, 1));
         receiver_idling = 1'($urandom_range(0, 1));
         sent = 0;
         while (sent < 12) begin
            len = $urandom_range(1, 12);
            send_run(len, 1'b1);
            sent += len;
         end
      end
      sender_idling = 1'b1;
      receiver_idling = 1'b1;
   endtask

   task automatic test_width_change_mid_run();
      write_shelf_width(16'd40);
      send_run(8, 1'b0);
      write_shelf_width(16'hFFFF);
      send_run(8, 1'b1);
   endtask

   task automatic test_long_receiver_hold();
      write_shelf_width(16'd100);
      sender_idling = 1'b0;
      hold_off_cycles = 300;
      send_run(15, 1'b1);
      send_run(15, 1'b1);
      sender_idling = 1'b1;
   endtask

   task automatic test_steady_stream();
      write_shelf_width(16'($urandom_range(50, 400)));
      sender_idling = 1'b0;
      receiver_idling = 1'b0;
      send_run(10, 1'b1);
      send_run(10, 1'b1);
   endtask

   initial begin
      shelf_width_now = SHELF_WIDTH_RESET;
      clear_shelf_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_default_width();
      test_zero_width_and_drop();
      test_random_widths();
      test_width_change_mid_run();
      test_long_receiver_hold();
      test_steady_stream();

      wait_drained();
      repeat (SHELVES + 40) @(posedge clock);
      $display("Packed %0d rectangles in %0d closed runs over %0d shelf width settings.",
               items_sent, runs_sent, widths_written + 1);
      $display("Checked %0d result beats; %0d rectangles were dropped on full shelves.",
               beats_checked, drops_seen);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout: %0d result beats still outstanding.", pending_results.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
